### hw/rtl/apab_pkg.sv
// ----------------------------------------------------------------------------
// apab_pkg
// Shared types and constants for the ARGB pixel alpha blender: mode codes,
// register indexes and the configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package apab_pkg;

	// number of glyph gray levels; the top level is the opaque coverage
	localparam int GRAY_LEVELS = 256;

	localparam logic [7:0] COV_OPAQUE   = 8'(GRAY_LEVELS - 1);
	localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
	localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

	// blend modes
	localparam logic [1:0] MODE_FILL  = 2'd0;
	localparam logic [1:0] MODE_BLIT  = 2'd1;
	localparam logic [1:0] MODE_GLYPH = 2'd2;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_BLEND_MODE = 2'd0;
	localparam logic [1:0] REG_FILL_COLOR = 2'd1;
	localparam logic [1:0] REG_NO_ALPHA   = 2'd2;

	localparam int ADDR_W = 4;

	typedef struct packed {
		logic [1:0]  blend_mode;
		logic [31:0] fill_color;
		logic        force_alpha_full;
	} cfg_t;

endpackage

`default_nettype wire

### hw/rtl/apab_regs.sv
// ----------------------------------------------------------------------------
// apab_regs
// Configuration register file on the APB-style port: mode, fill color and
// the forced full alpha flag, with read back.
// ----------------------------------------------------------------------------
`default_nettype none

module apab_regs
	import apab_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	logic [1:0]  blend_mode_q;
	logic [31:0] fill_color_q;
	logic        no_alpha_q;
	logic        wr_en;
	logic [1:0]  reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// register writes on the access phase of a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_mode_q <= 2'd0;
			fill_color_q <= 32'd0;
			no_alpha_q   <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_BLEND_MODE: blend_mode_q <= pwdata[1:0];
				REG_FILL_COLOR: fill_color_q <= pwdata;
				REG_NO_ALPHA:   no_alpha_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read back mux
	always_comb begin
		unique case (reg_idx)
			REG_BLEND_MODE: prdata = {30'd0, blend_mode_q};
			REG_FILL_COLOR: prdata = fill_color_q;
			REG_NO_ALPHA:   prdata = {31'd0, no_alpha_q};
			default:        prdata = 32'd0;
		endcase
	end

	assign cfg.blend_mode       = blend_mode_q;
	assign cfg.fill_color       = fill_color_q;
	assign cfg.force_alpha_full = no_alpha_q;

endmodule

`default_nettype wire

### hw/rtl/apab_mix.sv
// ----------------------------------------------------------------------------
// apab_mix
// One color channel: d + (((s - d) * a) mod 2^16 >> 8), wrapped to 8 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module apab_mix (
	input  wire logic [7:0] src,
	input  wire logic [7:0] dst,
	input  wire logic [7:0] alpha,
	output logic      [7:0] mixed
);

	logic [15:0] diff;
	logic [15:0] prod;

	// signed difference held as a 16-bit wrap, product kept to 16 bits
	assign diff  = {8'd0, src} - {8'd0, dst};
	assign prod  = 16'(diff * {8'd0, alpha});
	assign mixed = dst + prod[15:8];

endmodule

`default_nettype wire

### hw/rtl/apab_core.sv
// ----------------------------------------------------------------------------
// apab_core
// Blend datapath: picks the blend alpha and source color for the mode,
// detects opaque and skipped pixels, and mixes the three color channels.
// ----------------------------------------------------------------------------
`default_nettype none

module apab_core
	import apab_pkg::*;
(
	input  wire cfg_t         cfg,
	input  wire logic [31:0]  source_pixel,
	input  wire logic [7:0]   coverage,
	input  wire logic [31:0]  dest_pixel,
	output logic      [31:0]  result_pixel,
	output logic              write_enable
);

	logic [7:0]  alpha;
	logic [31:0] src_color;
	logic        opaque;
	logic        we;
	logic [7:0]  mix_r;
	logic [7:0]  mix_g;
	logic [7:0]  mix_b;
	logic [7:0]  top_byte;

	// alpha source and skip/opaque decisions per mode
	always_comb begin
		alpha     = ALPHA_CLEAR;
		src_color = cfg.fill_color;
		opaque    = 1'b0;
		we        = 1'b0;
		unique case (cfg.blend_mode)
			MODE_FILL: begin
				alpha  = cfg.fill_color[31:24];
				opaque = (alpha == ALPHA_OPAQUE);
				we     = 1'b1;
			end
			MODE_BLIT: begin
				alpha     = source_pixel[31:24];
				src_color = source_pixel;
				opaque    = (alpha == ALPHA_OPAQUE);
				we        = (alpha != ALPHA_CLEAR);
			end
			MODE_GLYPH: begin
				alpha  = coverage;
				opaque = (coverage == COV_OPAQUE);
				we     = (coverage != ALPHA_CLEAR);
			end
			default: ;
		endcase
	end

	// per-channel mixers
	apab_mix u_mix_r (
		.src(src_color[23:16]), .dst(dest_pixel[23:16]), .alpha(alpha), .mixed(mix_r)
	);
	apab_mix u_mix_g (
		.src(src_color[15:8]), .dst(dest_pixel[15:8]), .alpha(alpha), .mixed(mix_g)
	);
	apab_mix u_mix_b (
		.src(src_color[7:0]), .dst(dest_pixel[7:0]), .alpha(alpha), .mixed(mix_b)
	);

	// opaque writes replace rgb, optionally forcing alpha to full
	assign top_byte = cfg.force_alpha_full ? ALPHA_OPAQUE : dest_pixel[31:24];

	always_comb begin
		if (!we) begin
			result_pixel = dest_pixel;
		end else if (opaque) begin
			result_pixel = {top_byte, src_color[23:0]};
		end else begin
			result_pixel = {dest_pixel[31:24], mix_r, mix_g, mix_b};
		end
	end

	assign write_enable = we;

endmodule

`default_nettype wire

### hw/rtl/argb_pixel_alpha_blender.sv
// ----------------------------------------------------------------------------
// argb_pixel_alpha_blender
// ARGB8888 "over" blender: one destination pixel in, one blended pixel and
// a write flag out, in fill, blit or glyph mode.
// ----------------------------------------------------------------------------
// path: an accepted pixel passes the input register, then the result register, and is strobed on done
// throughput: one pixel per cycle; busy is always low, the input register
//   and the result register each hold one pixel in flight
// results are shown for one cycle only; the receiver cannot stall
// reset: config registers clear to zero (fill mode, black), no pixels in flight
`default_nettype none

module argb_pixel_alpha_blender
	import apab_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	// pixel input
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [31:0]       source_pixel,
	input  wire logic [7:0]        coverage,
	input  wire logic [31:0]       dest_pixel,
	// pixel result
	output logic                   done,
	output logic      [31:0]       result_pixel,
	output logic                   write_enable
);

	cfg_t        cfg;
	logic        accept;
	logic        valid_s1;
	logic [31:0] source_pixel_s1;
	logic [7:0]  coverage_s1;
	logic [31:0] dest_pixel_s1;
	logic [31:0] blend_pixel;
	logic        blend_we;
	logic        valid_s2;
	logic [31:0] result_pixel_s2;
	logic        write_enable_s2;

	apab_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (accept) begin
			source_pixel_s1 <= source_pixel;
			coverage_s1     <= coverage;
			dest_pixel_s1   <= dest_pixel;
		end
	end

	apab_core u_core (
		.cfg         (cfg),
		.source_pixel(source_pixel_s1),
		.coverage    (coverage_s1),
		.dest_pixel  (dest_pixel_s1),
		.result_pixel(blend_pixel),
		.write_enable(blend_we)
	);

	// result register
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_pixel_s2 <= blend_pixel;
			write_enable_s2 <= blend_we;
		end
	end

	assign done         = valid_s2;
	assign result_pixel = result_pixel_s2;
	assign write_enable = write_enable_s2;

endmodule

`default_nettype wire

### dv/argb_pixel_alpha_blender_tb.sv
// ----------------------------------------------------------------------------
// argb_pixel_alpha_blender_tb
// Self-checking bench for the ARGB pixel blender. Registers are programmed
// over APB and read back. Each phase then streams pixels through the start
// handshake, with random sender gaps in most phases. Every result strobe is checked
// against a blend computed here, field by field, in transfer order. Directed corner
// pixels come first, then random phases in all modes, including the unused one.
// ----------------------------------------------------------------------------
`default_nettype none

module argb_pixel_alpha_blender_tb;
	import apab_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int RANDOM_PHASES = 16;
	localparam int PHASE_PIXELS  = 108;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct {
		logic [31:0] source;
		logic [7:0]  cov;
		logic [31:0] dest;
	} pixel_item_t;

	typedef struct {
		logic [31:0] pixel;
		logic        wr;
	} blend_result_t;

	// clock, reset and block ports
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              start = 1'b0;
	logic              busy;
	logic [31:0]       source_pixel = '0;
	logic [7:0]        coverage = '0;
	logic [31:0]       dest_pixel = '0;
	logic              done;
	logic [31:0]       result_pixel;
	logic              write_enable;

	// register shadow used for prediction
	cfg_t shadow_cfg = '0;

	pixel_item_t   pixel_queue[$];
	blend_result_t expected_pixels[$];

	bit gaps_on = 1'b1;
	int idle_left = 0;
	int error_count = 0;
	int pixels_checked = 0;
	int pixels_written = 0;
	int settings_used = 0;
	int cycle_count = 0;

	argb_pixel_alpha_blender DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.start        (start),
		.busy         (busy),
		.source_pixel (source_pixel),
		.coverage     (coverage),
		.dest_pixel   (dest_pixel),
		.done         (done),
		.result_pixel (result_pixel),
		.write_enable (write_enable)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// one color channel: d + ((s - d) * a mod 2^16) >> 8, wrapped to 8 bits
	function automatic logic [7:0] mix_channel8(logic [7:0] s, logic [7:0] d, logic [7:0] a);
		logic [15:0] diff;
		logic [15:0] prod;
		diff = {8'h00, s} - {8'h00, d};
		prod = diff * {8'h00, a};
		return d + prod[15:8];
	endfunction

	// rgb blend keeping the destination alpha byte
	function automatic logic [31:0] blend_rgb(logic [31:0] s, logic [31:0] d, logic [7:0] a);
		return {d[31:24], mix_channel8(s[23:16], d[23:16], a),
			mix_channel8(s[15:8], d[15:8], a), mix_channel8(s[7:0], d[7:0], a)};
	endfunction

	function automatic logic [31:0] opaque_pixel(logic [31:0] s, logic [31:0] d);
		return {shadow_cfg.force_alpha_full ? ALPHA_OPAQUE : d[31:24], s[23:0]};
	endfunction

	// expected pixel and write flag for one accepted input
	function automatic blend_result_t blend_pixel(pixel_item_t it);
		blend_result_t r;
		logic [7:0] a;
		r.pixel = it.dest;
		r.wr = 1'b0;
		case (shadow_cfg.blend_mode)
			MODE_FILL: begin
				a = shadow_cfg.fill_color[31:24];
				r.pixel = (a == ALPHA_OPAQUE) ? opaque_pixel(shadow_cfg.fill_color, it.dest)
					: blend_rgb(shadow_cfg.fill_color, it.dest, a);
				r.wr = 1'b1;
			end
			MODE_BLIT: begin
				a = it.source[31:24];
				if (a == ALPHA_OPAQUE) begin
					r.pixel = opaque_pixel(it.source, it.dest);
					r.wr = 1'b1;
				end else if (a != ALPHA_CLEAR) begin
					r.pixel = blend_rgb(it.source, it.dest, a);
					r.wr = 1'b1;
				end
			end
			MODE_GLYPH: begin
				if (it.cov == COV_OPAQUE) begin
					r.pixel = opaque_pixel(shadow_cfg.fill_color, it.dest);
					r.wr = 1'b1;
				end else if (it.cov != ALPHA_CLEAR) begin
					r.pixel = blend_rgb(shadow_cfg.fill_color, it.dest, it.cov);
					r.wr = 1'b1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// random pixel, biased toward clear and opaque alpha and coverage
	function automatic pixel_item_t random_pixel();
		pixel_item_t it;
		it.source = $urandom;
		it.cov = 8'($urandom_range(0, 255));
		it.dest = $urandom;
		case ($urandom_range(0, 7))
			0: it.source[31:24] = ALPHA_CLEAR;
			1: it.source[31:24] = ALPHA_OPAQUE;
			default: ;
		endcase
		case ($urandom_range(0, 9))
			0: it.cov = ALPHA_CLEAR;
			1: it.cov = COV_OPAQUE;
			2: it.cov = 8'h01;
			3: it.cov = 8'hfe;
			default: ;
		endcase
		case ($urandom_range(0, 15))
			0: it.dest = '0;
			1: it.dest = '1;
			default: ;
		endcase
		return it;
	endfunction

	task automatic add_pixel(logic [31:0] s, logic [7:0] c, logic [31:0] d);
		pixel_item_t it;
		it.source = s;
		it.cov = c;
		it.dest = d;
		pixel_queue.push_back(it);
	endtask

	// apb transfer: setup cycle, then access until pready
	task automatic apb_transfer(logic [1:0] idx, logic wr, logic [31:0] wdata,
		output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ADDR_W'(4 * idx);
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		if (wr) begin
			case (idx)
				REG_BLEND_MODE: shadow_cfg.blend_mode = wdata[1:0];
				REG_FILL_COLOR: shadow_cfg.fill_color = wdata;
				REG_NO_ALPHA:   shadow_cfg.force_alpha_full = wdata[0];
				default: ;
			endcase
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic read_check(logic [1:0] idx, logic [31:0] want);
		logic [31:0] got;
		apb_transfer(idx, 1'b0, '0, got);
		if (got !== want) begin
			$display("%0t: register %0d readback expected %h actual %h", $time, idx, want, got);
			error_count++;
		end
	endtask

	// write all three registers, then read them back
	task automatic program_regs(logic [1:0] mode, logic [31:0] color, logic no_alpha);
		logic [31:0] unused;
		apb_transfer(REG_BLEND_MODE, 1'b1, {30'h0, mode}, unused);
		apb_transfer(REG_FILL_COLOR, 1'b1, color, unused);
		apb_transfer(REG_NO_ALPHA, 1'b1, {31'h0, no_alpha}, unused);
		read_check(REG_BLEND_MODE, {30'h0, mode});
		read_check(REG_FILL_COLOR, color);
		read_check(REG_NO_ALPHA, {31'h0, no_alpha});
		settings_used++;
	endtask

	// hold off until every queued pixel has been sent and its result seen
	task automatic drain();
		do @(posedge clk); while (pixel_queue.size() != 0 || start || expected_pixels.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// pixel driver: one transfer per accepting edge, random gap bursts while gaps_on is set
	always @(posedge clk) begin
		if (arst_n && (!start || !busy)) begin
			if (idle_left != 0) begin
				idle_left--;
				start <= 1'b0;
			end else if (pixel_queue.size() != 0) begin
				start <= 1'b1;
				source_pixel <= pixel_queue[0].source;
				coverage <= pixel_queue[0].cov;
				dest_pixel <= pixel_queue[0].dest;
				void'(pixel_queue.pop_front());
				if (gaps_on && $urandom_range(0, 5) == 0)
					idle_left = $urandom_range(1, 19);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: predict on accepted inputs, check each result strobe
	always @(posedge clk) begin
		blend_result_t want;
		pixel_item_t it;
		if (arst_n) begin
			if (start && !busy) begin
				it.source = source_pixel;
				it.cov = coverage;
				it.dest = dest_pixel;
				expected_pixels.push_back(blend_pixel(it));
			end
			if (done) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t: result with none expected, actual pixel %h write %b",
						$time, result_pixel, write_enable);
					error_count++;
				end else begin
					want = expected_pixels.pop_front();
					pixels_checked++;
					if (write_enable === 1'b1)
						pixels_written++;
					if (result_pixel !== want.pixel) begin
						$display("%0t: result_pixel expected %h actual %h",
							$time, want.pixel, result_pixel);
						error_count++;
					end
					if (write_enable !== want.wr) begin
						$display("%0t: write_enable expected %b actual %b",
							$time, want.wr, write_enable);
						error_count++;
					end
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_pixels.size());
			$display("argb_pixel_alpha_blender regression: fail");
			$finish;
		end
	end

	// stimulus sequence
	initial begin
		logic [1:0]  mode;
		logic [31:0] color;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// fill mode: partial, opaque and clear fill alpha
		program_regs(MODE_FILL, 32'h8040c0ff, 1'b0);
		add_pixel('0, '0, '0);
		add_pixel('1, '1, '1);
		add_pixel('0, '0, 32'h12345678);
		drain();
		program_regs(MODE_FILL, 32'hff123456, 1'b1);
		add_pixel('0, '0, 32'h00abcdef);
		add_pixel('1, '1, '1);
		drain();
		program_regs(MODE_FILL, 32'h00abcdef, 1'b0);
		add_pixel('0, '0, 32'h7f102030);
		drain();

		// blit mode: clear, opaque and edge alphas
		program_regs(MODE_BLIT, '0, 1'b0);
		add_pixel(32'h00ffffff, '0, 32'h80000000);
		add_pixel(32'hff00ff00, '0, 32'h01ff00ff);
		add_pixel(32'h01ffffff, '0, '0);
		add_pixel(32'hfeffffff, '0, '0);
		add_pixel(32'h80123456, '0, '1);
		drain();
		program_regs(MODE_BLIT, '1, 1'b1);
		add_pixel(32'hffabcdef, '0, '0);
		drain();

		// glyph mode: no, partial and full coverage
		program_regs(MODE_GLYPH, 32'h40ff8000, 1'b0);
		add_pixel('1, 8'h00, 32'h55aa55aa);
		add_pixel('1, 8'h01, 32'h55aa55aa);
		add_pixel('0, 8'h7f, 32'hc0204060);
		add_pixel('0, 8'hfe, '0);
		add_pixel('0, COV_OPAQUE, 32'h3c112233);
		drain();
		program_regs(MODE_GLYPH, '1, 1'b1);
		add_pixel('0, COV_OPAQUE, '0);
		drain();

		// unused mode value never writes
		program_regs(MODE_UNUSED, '1, 1'b1);
		add_pixel('1, COV_OPAQUE, 32'h12345678);
		add_pixel('0, '0, '0);
		drain();

		// random phases, each under its own register setting
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			mode = 2'(ph % 4);
			if (mode == MODE_UNUSED && ph % 8 != 3)
				mode = MODE_BLIT;
			case (ph % 5)
				0: color = '1;
				1: color = {ALPHA_OPAQUE, 24'($urandom)};
				2: color = {ALPHA_CLEAR, 24'($urandom)};
				3: color = '0;
				default: color = $urandom;
			endcase
			program_regs(mode, color, 1'($urandom_range(0, 1)));
			gaps_on = (ph < RANDOM_PHASES - 2) && (ph % 3 != 1);
			for (int i = 0; i < PHASE_PIXELS; i++)
				pixel_queue.push_back(random_pixel());
			drain();
		end

		repeat (6) @(posedge clk);
		$display("covered fill, blit, glyph and unused modes over %0d register settings",
			settings_used);
		$display("%0d pixels checked, %0d written, %0d skipped, %0d errors",
			pixels_checked, pixels_written, pixels_checked - pixels_written, error_count);
		if (error_count == 0)
			$display("argb_pixel_alpha_blender regression: pass");
		else
			$display("argb_pixel_alpha_blender regression: fail");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
hw/rtl/apab_pkg.sv
hw/rtl/apab_regs.sv
hw/rtl/apab_mix.sv
hw/rtl/apab_core.sv
hw/rtl/argb_pixel_alpha_blender.sv
dv/argb_pixel_alpha_blender_tb.sv
